[rtl/ipc_pkg.sv]
// Shared types, codes and helper functions for the infix-to-postfix converter.
// Used by the interfaces and by every RTL module of the block; depends on nothing.
package ipc_pkg;

    localparam int STACK_DEPTH_DEFAULT = 32;
    localparam int QUEUE_DEPTH         = 2;
    localparam int NUM_W               = 64;

    typedef enum logic [2:0] {
        TOK_NUM    = 3'd0,
        TOK_OP     = 3'd1,
        TOK_LPAREN = 3'd2,
        TOK_RPAREN = 3'd3,
        TOK_END    = 3'd4
    } tok_kind_t;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_MOD = 3'd4,
        OP_POW = 3'd5
    } op_code_t;

    typedef enum logic [1:0] {
        OUT_NUM   = 2'd0,
        OUT_OP    = 2'd1,
        OUT_END   = 2'd2,
        OUT_ERROR = 2'd3
    } out_kind_t;

    typedef enum logic [1:0] {
        CAUSE_NONE     = 2'd0,
        CAUSE_RPAREN   = 2'd1,
        CAUSE_LPAREN   = 2'd2,
        CAUSE_OVERFLOW = 2'd3
    } err_cause_t;

    // Stack entry: bit 3 marks a left paren, bits 2..0 hold an operator code.
    localparam logic [3:0] PAREN_MARK = 4'b1000;

    // Decoded token handed from the front end to the back end.
    typedef struct packed {
        tok_kind_t        kind;
        logic [2:0]       op;
        logic [1:0]       prec;
        logic             right_assoc;
        logic             unary_ok;
        logic [NUM_W-1:0] number;
    } cmd_t;

    function automatic logic [1:0] prec_of(input logic [2:0] op);
        logic [1:0] p;
        if (op <= OP_SUB)
            p = 2'd1;
        else if (op <= OP_MOD)
            p = 2'd2;
        else if (op == OP_POW)
            p = 2'd3;
        else
            p = 2'd0;
        return p;
    endfunction

    // True when the stack entry must be popped before an incoming operator.
    function automatic logic must_pop(input logic [3:0] entry, input logic [1:0] prec,
                                      input logic right_assoc);
        logic [1:0] tp;
        tp = prec_of(entry[2:0]);
        return !entry[3] && ((tp > prec) || ((tp == prec) && !right_assoc));
    endfunction

endpackage

[rtl/ipc_if.sv]
// Valid/ready channel interfaces for token beats and result beats.
// Depends on ipc_pkg for the payload widths.
interface ipc_tok_if;
    logic                     valid;
    logic                     ready;
    logic [2:0]               token_kind;
    logic [2:0]               op_code;
    logic [ipc_pkg::NUM_W-1:0] number_value;

    modport source (output valid, output token_kind, output op_code, output number_value,
                    input ready);
    modport sink   (input valid, input token_kind, input op_code, input number_value,
                    output ready);
endinterface

interface ipc_res_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               out_kind;
    logic [2:0]               out_op;
    logic [ipc_pkg::NUM_W-1:0] out_number;
    logic [1:0]               error_cause;
    logic                     last_of_run;

    modport source (output valid, output out_kind, output out_op, output out_number,
                    output error_cause, output last_of_run, input ready);
    modport sink   (input valid, input out_kind, input out_op, input out_number,
                    input error_cause, input last_of_run, output ready);
endinterface

[rtl/infix_to_postfix_converter_top.sv]
// Infix-to-postfix converter: token beats in, postfix result beats out.
// A token beat of a known kind is written into the queue when accepted; the back end takes
// it from the queue head and registers each result beat, holding while a beat waits on ready.
// The back end gives result beats one by one; pushing an operator or left paren and dropping
// the matching left paren are steps of their own that give no result beat.
// Reset clears the stack count and the error state; the stack memory needs no clearing.
module infix_to_postfix_converter_top #(
    parameter int STACK_DEPTH = ipc_pkg::STACK_DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    ipc_tok_if.sink    tokens,
    ipc_res_if.source  results
);

    logic          q_push, q_full, q_pop, q_not_empty;
    ipc_pkg::cmd_t q_data, q_head;

    ipc_front u_front (
        .tokens (tokens),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_data)
    );

    ipc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    ipc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_not_empty),
        .cmd     (q_head),
        .q_pop   (q_pop),
        .results (results)
    );

endmodule

[rtl/ipc_front.sv]
// Front end: accepts token beats, drops unknown kinds and decodes the rest.
// Depends on ipc_pkg and ipc_tok_if; feeds ipc_queue.
module ipc_front (
    ipc_tok_if.sink         tokens,
    input  logic            q_full,
    output logic            q_push,
    output ipc_pkg::cmd_t   q_data
);

    logic accept;

    assign tokens.ready = !q_full;
    assign accept       = tokens.valid && !q_full;

    // Token kinds above the end marker are consumed without effect.
    assign q_push = accept && (tokens.token_kind <= ipc_pkg::TOK_END);

    always_comb
    begin
        q_data             = '0;
        q_data.kind        = ipc_pkg::tok_kind_t'(tokens.token_kind);
        q_data.op          = tokens.op_code;
        q_data.prec        = ipc_pkg::prec_of(tokens.op_code);
        q_data.right_assoc = (tokens.op_code == ipc_pkg::OP_POW);
        q_data.unary_ok    = (tokens.op_code == ipc_pkg::OP_ADD) ||
                             (tokens.op_code == ipc_pkg::OP_SUB);
        q_data.number      = tokens.number_value;
    end

endmodule

[rtl/ipc_queue.sv]
// Short FIFO of decoded tokens between the front end and the back end.
// Depends on ipc_pkg for the entry type and depth.
module ipc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ipc_pkg::cmd_t push_data,
    input  logic          pop,
    output logic          full,
    output logic          not_empty,
    output ipc_pkg::cmd_t head
);

    localparam int PTR_W = (ipc_pkg::QUEUE_DEPTH > 1) ? $clog2(ipc_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(ipc_pkg::QUEUE_DEPTH + 1);

    ipc_pkg::cmd_t     entry_reg [ipc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full      = (count_reg == CNT_W'(ipc_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            if (wr_ptr_reg == PTR_W'(ipc_pkg::QUEUE_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            if (rd_ptr_reg == PTR_W'(ipc_pkg::QUEUE_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

[rtl/ipc_back.sv]
// Back end: shunting-yard rule on the operator stack, at most one result per cycle.
// Depends on ipc_pkg and ipc_res_if; takes decoded tokens from ipc_queue.
module ipc_back #(
    parameter int STACK_DEPTH = ipc_pkg::STACK_DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  ipc_pkg::cmd_t cmd,
    output logic          q_pop,
    ipc_res_if.source     results
);

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

    logic [3:0]        stack_mem [STACK_DEPTH];
    logic [3:0]        top_reg;
    logic [3:0]        below_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              unary_reg, unary_next;
    logic              discard_reg, discard_next;
    logic              zero_done_reg, zero_done_next;

    logic                      out_valid_reg;
    ipc_pkg::out_kind_t        out_kind_reg;
    logic [2:0]                out_op_reg;
    logic [ipc_pkg::NUM_W-1:0] out_number_reg;
    ipc_pkg::err_cause_t       out_cause_reg;
    logic                      out_last_reg;

    logic                      act;
    logic                      done;
    logic                      push;
    logic [3:0]                push_data;
    logic                      have_top, have_below, full;
    logic                      pop_top, stop_below;
    logic                      r_valid;
    ipc_pkg::out_kind_t        r_kind;
    logic [2:0]                r_op;
    logic [ipc_pkg::NUM_W-1:0] r_number;
    ipc_pkg::err_cause_t       r_cause;
    logic                      r_last;
    logic [ADDR_W-1:0]         top_idx, below_idx;

    assign act        = q_valid && (!out_valid_reg || results.ready);
    assign q_pop      = act && done;
    assign have_top   = (count_reg != '0);
    assign have_below = (count_reg > CNT_W'(1));
    assign full       = (count_reg == CNT_W'(STACK_DEPTH));
    assign pop_top    = have_top && ipc_pkg::must_pop(top_reg, cmd.prec, cmd.right_assoc);
    assign stop_below = !have_below ||
                        !ipc_pkg::must_pop(below_reg, cmd.prec, cmd.right_assoc);

    always_comb
    begin
        done           = 1'b0;
        push           = 1'b0;
        push_data      = '0;
        count_next     = count_reg;
        unary_next     = unary_reg;
        discard_next   = discard_reg;
        zero_done_next = zero_done_reg;
        r_valid        = 1'b0;
        r_kind         = ipc_pkg::OUT_NUM;
        r_op           = '0;
        r_number       = '0;
        r_cause        = ipc_pkg::CAUSE_NONE;
        r_last         = 1'b0;

        if (act)
        begin
            if (cmd.kind == ipc_pkg::TOK_END)
            begin
                priority if (have_top && top_reg[3])
                begin
                    r_valid    = 1'b1;
                    r_kind     = ipc_pkg::OUT_ERROR;
                    r_cause    = ipc_pkg::CAUSE_LPAREN;
                    count_next = '0;
                end
                else if (have_top)
                begin
                    r_valid    = 1'b1;
                    r_kind     = ipc_pkg::OUT_OP;
                    r_op       = top_reg[2:0];
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    r_valid      = 1'b1;
                    r_kind       = ipc_pkg::OUT_END;
                    r_last       = 1'b1;
                    discard_next = 1'b0;
                    unary_next   = 1'b1;
                    done         = 1'b1;
                end
            end
            else if (discard_reg)
            begin
                done = 1'b1;
            end
            else
            begin
                unique case (cmd.kind)
                    ipc_pkg::TOK_NUM:
                    begin
                        r_valid    = 1'b1;
                        r_kind     = ipc_pkg::OUT_NUM;
                        r_number   = cmd.number;
                        r_last     = 1'b1;
                        unary_next = 1'b0;
                        done       = 1'b1;
                    end
                    ipc_pkg::TOK_OP:
                    begin
                        // The last flag of each beat is settled by looking one entry ahead.
                        priority if (cmd.unary_ok && unary_reg && !zero_done_reg)
                        begin
                            r_valid        = 1'b1;
                            r_kind         = ipc_pkg::OUT_NUM;
                            r_last         = !pop_top && !full;
                            zero_done_next = 1'b1;
                        end
                        else if (pop_top)
                        begin
                            r_valid    = 1'b1;
                            r_kind     = ipc_pkg::OUT_OP;
                            r_op       = top_reg[2:0];
                            r_last     = stop_below;
                            count_next = count_reg - CNT_W'(1);
                        end
                        else if (full)
                        begin
                            r_valid      = 1'b1;
                            r_kind       = ipc_pkg::OUT_ERROR;
                            r_cause      = ipc_pkg::CAUSE_OVERFLOW;
                            r_last       = 1'b1;
                            count_next   = '0;
                            discard_next = 1'b1;
                            done         = 1'b1;
                        end
                        else
                        begin
                            push       = 1'b1;
                            push_data  = {1'b0, cmd.op};
                            count_next = count_reg + CNT_W'(1);
                            unary_next = 1'b1;
                            done       = 1'b1;
                        end
                    end
                    ipc_pkg::TOK_LPAREN:
                    begin
                        if (full)
                        begin
                            r_valid      = 1'b1;
                            r_kind       = ipc_pkg::OUT_ERROR;
                            r_cause      = ipc_pkg::CAUSE_OVERFLOW;
                            r_last       = 1'b1;
                            count_next   = '0;
                            discard_next = 1'b1;
                        end
                        else
                        begin
                            push       = 1'b1;
                            push_data  = ipc_pkg::PAREN_MARK;
                            count_next = count_reg + CNT_W'(1);
                            unary_next = 1'b1;
                        end
                        done = 1'b1;
                    end
                    ipc_pkg::TOK_RPAREN:
                    begin
                        priority if (have_top && top_reg[3])
                        begin
                            count_next = count_reg - CNT_W'(1);
                            unary_next = 1'b0;
                            done       = 1'b1;
                        end
                        else if (have_top)
                        begin
                            r_valid    = 1'b1;
                            r_kind     = ipc_pkg::OUT_OP;
                            r_op       = top_reg[2:0];
                            r_last     = have_below && below_reg[3];
                            count_next = count_reg - CNT_W'(1);
                        end
                        else
                        begin
                            r_valid      = 1'b1;
                            r_kind       = ipc_pkg::OUT_ERROR;
                            r_cause      = ipc_pkg::CAUSE_RPAREN;
                            r_last       = 1'b1;
                            count_next   = '0;
                            discard_next = 1'b1;
                            done         = 1'b1;
                        end
                    end
                    default:
                    begin
                        done = 1'b1;
                    end
                endcase
            end

            if (done)
                zero_done_next = 1'b0;
        end
    end

    assign top_idx   = ADDR_W'(count_next - CNT_W'(1));
    assign below_idx = ADDR_W'(count_next - CNT_W'(2));

    // The top two entries are kept in registers; a push bypasses the memory read.
    always_ff @(posedge clk)
    begin
        if (push)
            stack_mem[count_reg[ADDR_W-1:0]] <= push_data;
        if (push)
        begin
            top_reg   <= push_data;
            below_reg <= top_reg;
        end
        else
        begin
            top_reg   <= stack_mem[top_idx];
            below_reg <= stack_mem[below_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            unary_reg     <= 1'b1;
            discard_reg   <= 1'b0;
            zero_done_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            unary_reg     <= unary_next;
            discard_reg   <= discard_next;
            zero_done_reg <= zero_done_next;
            if (r_valid)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r_valid)
        begin
            out_kind_reg   <= r_kind;
            out_op_reg     <= r_op;
            out_number_reg <= r_number;
            out_cause_reg  <= r_cause;
            out_last_reg   <= r_last;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.out_kind    = out_kind_reg;
    assign results.out_op      = out_op_reg;
    assign results.out_number  = out_number_reg;
    assign results.error_cause = out_cause_reg;
    assign results.last_of_run = out_last_reg;

endmodule
